/* src/eqseg_pkg.sv */
// Package for the equalized segment position lookup.
// Holds the shared sizes, command codes and queue/result types.
// No dependencies.
package eqseg_pkg;

  localparam int MAX_SEGMENTS = 256;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int CFG_W        = 9;
  localparam int ENTRY_W      = 8;
  localparam int VAL_W        = 32;
  localparam int FRAC_W       = 16;
  localparam int POS_W        = FRAC_W + 1;
  localparam int FOUND_W      = 8;
  localparam int DIV_CNT_W    = $clog2(FRAC_W);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_W-1:0] SEG_COUNT_RESET = CFG_W'(256);
  localparam logic [POS_W-1:0] FULL_SCALE      = POS_W'(1) << FRAC_W;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // One classified word waiting for the back end. For a query the value
  // travels in the lo field and the other fields are unused.
  typedef struct packed {
    cmd_t                     cmd;
    logic                     wr_ok;
    logic [IDX_W-1:0]         idx;
    logic signed [VAL_W-1:0]  lo;
    logic signed [VAL_W-1:0]  hi;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [FOUND_W-1:0] found;
  } result_t;

endpackage

/* src/equalized_segment_position_lookup.sv */
// Equalized segment position lookup. A table write is done as the back end pops it. A query
// runs the first-entry check, then the last-entry check, and ends there if either decides;
// otherwise a binary search runs (at most 8 probes, one registered table read each) and a
// match runs the serial division, one quotient bit a step, before the result reaches out_tvalid.
// Words run one at a time; a held result word stalls the back end.
// Synchronous active-low reset clears queue, control and result valid; segment_count is 256.
module equalized_segment_position_lookup (
  input  logic         clk,
  input  logic         rst_n,
  // Input channel.
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tdata, low bit up: entry_index[7:0], bound_low[39:8],
  // bound_high[71:40], query_value[103:72].
  input  logic [103:0] in_tdata,
  // in_tuser: cmd[0] (0 writes an entry, 1 queries).
  input  logic [0:0]   in_tuser,
  // Result channel.
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata, low bit up: position_fraction[16:0], segment_found[24:17],
  // zero fill[31:25].
  output logic [31:0]  out_tdata,
  // Configuration: segment_count.
  input  logic         cfg_we,
  input  logic [8:0]   cfg_wdata
);

  // The front end decodes each accepted word into a queue item; writes and
  // queries share the queue so table updates stay in order with searches.
  logic                         q_full;
  logic                         q_push;
  eqseg_pkg::item_t             q_item;
  logic                         q_pop;
  logic                         q_not_empty;
  eqseg_pkg::item_t             q_head;
  logic [eqseg_pkg::CNT_W-1:0]  eff_count;
  eqseg_pkg::result_t           res;

  eqseg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item),
    .eff_count (eff_count)
  );

  eqseg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // The back end runs one item at a time and parks its answer in an output
  // register, so it can start the next queued item while the result waits.
  eqseg_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .eff_count   (eff_count),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res         (res)
  );

  assign out_tdata = {7'b0, res.found, res.pos};

endmodule

/* src/eqseg_front.sv */
// Front end of the equalized segment position lookup: takes input words,
// classifies them into queue items and holds the segment count register.
// Depends on eqseg_pkg.
module eqseg_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [103:0]                 in_tdata,
  input  logic [0:0]                   in_tuser,
  input  logic                         cfg_we,
  input  logic [eqseg_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                         q_full,
  output logic                         q_push,
  output eqseg_pkg::item_t             q_item,
  output logic [eqseg_pkg::CNT_W-1:0]  eff_count
);

  logic [eqseg_pkg::CFG_W-1:0]   segment_count_r;
  logic [eqseg_pkg::ENTRY_W-1:0] entry_index;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      segment_count_r <= eqseg_pkg::SEG_COUNT_RESET;
    end else if (cfg_we) begin
      segment_count_r <= cfg_wdata;
    end
  end

  // A count of zero acts as one; a count beyond the table acts as its size.
  always_comb begin
    if (segment_count_r == '0) begin
      eff_count = eqseg_pkg::CNT_W'(1);
    end else if (32'(segment_count_r) > eqseg_pkg::MAX_SEGMENTS) begin
      eff_count = eqseg_pkg::CNT_W'(eqseg_pkg::MAX_SEGMENTS);
    end else begin
      eff_count = eqseg_pkg::CNT_W'(segment_count_r);
    end
  end

  assign in_tready   = !q_full;
  assign q_push      = in_tvalid && !q_full;
  assign entry_index = in_tdata[7:0];

  always_comb begin
    q_item.cmd   = eqseg_pkg::cmd_t'(in_tuser[0]);
    q_item.wr_ok = 32'(entry_index) < eqseg_pkg::MAX_SEGMENTS;
    q_item.idx   = eqseg_pkg::IDX_W'(entry_index);
    if (q_item.cmd == eqseg_pkg::CMD_QUERY) begin
      q_item.lo = in_tdata[103:72];
      q_item.hi = '0;
    end else begin
      q_item.lo = in_tdata[39:8];
      q_item.hi = in_tdata[71:40];
    end
  end

endmodule

/* src/eqseg_queue.sv */
// Short FIFO between the front and back ends of the lookup.
// Depends on eqseg_pkg.
module eqseg_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  eqseg_pkg::item_t  push_item,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output eqseg_pkg::item_t  head
);

  eqseg_pkg::item_t             slots_r [eqseg_pkg::QUEUE_DEPTH];
  logic [eqseg_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [eqseg_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [eqseg_pkg::QCNT_W-1:0] count_r;

  assign full      = count_r == eqseg_pkg::QCNT_W'(eqseg_pkg::QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == eqseg_pkg::QUEUE_DEPTH - 1) ? '0
                    : wr_ptr_r + eqseg_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == eqseg_pkg::QUEUE_DEPTH - 1) ? '0
                    : rd_ptr_r + eqseg_pkg::QPTR_W'(1);
      end
      count_r <= count_r + eqseg_pkg::QCNT_W'(push) - eqseg_pkg::QCNT_W'(pop);
    end
  end

endmodule

/* src/eqseg_back.sv */
// Back end of the lookup: owns the interval table, runs the bound checks,
// the binary search and the serial division, and holds the output register.
// Depends on eqseg_pkg.
module eqseg_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_not_empty,
  input  eqseg_pkg::item_t             q_head,
  output logic                         q_pop,
  input  logic [eqseg_pkg::CNT_W-1:0]  eff_count,
  output logic                         res_valid,
  input  logic                         res_ready,
  output eqseg_pkg::result_t           res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK_FIRST,
    S_CHK_LAST,
    S_SEARCH,
    S_DIVIDE,
    S_EMIT
  } state_t;

  localparam int REM_W = eqseg_pkg::CNT_W + 1;

  logic [2*eqseg_pkg::VAL_W-1:0] mem [eqseg_pkg::MAX_SEGMENTS];
  logic [2*eqseg_pkg::VAL_W-1:0] rd_data_r;
  logic                          rd_en;
  logic [eqseg_pkg::IDX_W-1:0]   rd_addr;
  logic                          wr_en;

  state_t                          state_r, state_nxt;
  logic signed [eqseg_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [eqseg_pkg::IDX_W-1:0]     lo_r, lo_nxt;
  logic [eqseg_pkg::IDX_W-1:0]     hi_r, hi_nxt;
  logic [eqseg_pkg::IDX_W-1:0]     mid_r, mid_nxt;
  logic [REM_W-1:0]                rem_r, rem_nxt;
  logic [eqseg_pkg::FRAC_W-1:0]    quo_r, quo_nxt;
  logic [eqseg_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  eqseg_pkg::result_t              pend_r, pend_nxt;
  logic                            res_valid_r, res_valid_nxt;
  eqseg_pkg::result_t              res_r, res_nxt;

  logic signed [eqseg_pkg::VAL_W-1:0] e_lo, e_hi;
  logic [eqseg_pkg::IDX_W-1:0]     last_idx;
  logic [eqseg_pkg::IDX_W-1:0]     gap;
  logic [REM_W-1:0]                rem_sh;
  logic                            rem_ge;

  assign e_lo     = rd_data_r[2*eqseg_pkg::VAL_W-1:eqseg_pkg::VAL_W];
  assign e_hi     = rd_data_r[eqseg_pkg::VAL_W-1:0];
  assign last_idx = eqseg_pkg::IDX_W'(eff_count - eqseg_pkg::CNT_W'(1));
  assign rem_sh   = {rem_r[REM_W-2:0], 1'b0};
  assign rem_ge   = rem_sh >= {1'b0, eff_count};

  assign res_valid = res_valid_r;
  assign res       = res_r;

  // Table storage: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[q_head.idx] <= {q_head.lo, q_head.hi};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    div_cnt_nxt   = div_cnt_r;
    pend_nxt      = pend_r;
    res_valid_nxt = res_valid_r && !res_ready;
    res_nxt       = res_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    gap           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (q_not_empty) begin
          q_pop = 1'b1;
          if (q_head.cmd == eqseg_pkg::CMD_WRITE) begin
            wr_en = q_head.wr_ok;
          end else begin
            val_nxt   = q_head.lo;
            rd_en     = 1'b1;
            rd_addr   = '0;
            state_nxt = S_CHK_FIRST;
          end
        end
      end
      S_CHK_FIRST: begin
        if (val_r < e_hi) begin
          pend_nxt  = '0;
          state_nxt = S_EMIT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = last_idx;
          state_nxt = S_CHK_LAST;
        end
      end
      S_CHK_LAST: begin
        lo_nxt  = '0;
        hi_nxt  = last_idx;
        mid_nxt = last_idx >> 1;
        if (val_r > e_lo) begin
          pend_nxt.pos   = eqseg_pkg::FULL_SCALE;
          pend_nxt.found = eqseg_pkg::FOUND_W'(last_idx);
          state_nxt      = S_EMIT;
        end else if (last_idx > eqseg_pkg::IDX_W'(1)) begin
          rd_en     = 1'b1;
          rd_addr   = last_idx >> 1;
          state_nxt = S_SEARCH;
        end else begin
          pend_nxt  = '0;
          state_nxt = S_EMIT;
        end
      end
      S_SEARCH: begin
        if (e_lo <= val_r && e_hi >= val_r) begin
          // Match: position is mid / count in Q0.16, one quotient bit a step.
          rem_nxt     = REM_W'(mid_r);
          quo_nxt     = '0;
          div_cnt_nxt = '0;
          state_nxt   = S_DIVIDE;
        end else begin
          if (e_hi < val_r) begin
            lo_nxt  = mid_r;
            gap     = hi_r - mid_r;
            mid_nxt = mid_r + (gap >> 1);
          end else begin
            hi_nxt  = mid_r;
            gap     = mid_r - lo_r;
            mid_nxt = mid_r - (gap >> 1);
          end
          if (gap > eqseg_pkg::IDX_W'(1)) begin
            rd_en   = 1'b1;
            rd_addr = mid_nxt;
          end else begin
            pend_nxt  = '0;
            state_nxt = S_EMIT;
          end
        end
      end
      S_DIVIDE: begin
        rem_nxt     = rem_ge ? rem_sh - {1'b0, eff_count} : rem_sh;
        quo_nxt     = {quo_r[eqseg_pkg::FRAC_W-2:0], rem_ge};
        div_cnt_nxt = div_cnt_r + eqseg_pkg::DIV_CNT_W'(1);
        if (32'(div_cnt_r) == eqseg_pkg::FRAC_W - 1) begin
          pend_nxt.pos   = eqseg_pkg::POS_W'({quo_r[eqseg_pkg::FRAC_W-2:0], rem_ge});
          pend_nxt.found = eqseg_pkg::FOUND_W'(mid_r);
          state_nxt      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!res_valid_r || res_ready) begin
          res_valid_nxt = 1'b1;
          res_nxt       = pend_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
    val_r     <= val_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    div_cnt_r <= div_cnt_nxt;
    pend_r    <= pend_nxt;
    res_r     <= res_nxt;
  end

endmodule

/* sim/tb.sv */
// Self-checking testbench for equalized_segment_position_lookup: interval table
// writes and position queries over the stream ports, every result word checked
// against a behavioral predictor or a directed expectation. Depends on eqseg_pkg and the block's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // A write item makes no result word, so after the last expected word the
  // block may still be busy with trailing writes, and the input queue holds
  // two words, so DRAIN_CYCLES leaves a safe margin.
  localparam int DRAIN_CYCLES = 64;
  localparam int ROUND_WORDS  = 30;
  localparam int ROUNDS       = 6;

  typedef enum logic {
    ROW_WORD,
    ROW_COUNT
  } row_kind_t;

  typedef struct packed {
    logic [eqseg_pkg::POS_W-1:0]   pos;
    logic [eqseg_pkg::FOUND_W-1:0] found;
  } placement_t;

  // One line of the directed stimulus table. A ROW_COUNT line reprograms
  // segment_count. A ROW_WORD line sends one word. When typed is set, the
  // expected result is taken from want and not from the predictor.
  typedef struct packed {
    row_kind_t                          kind;
    eqseg_pkg::cmd_t                    cmd;
    logic [eqseg_pkg::IDX_W-1:0]        idx;
    logic signed [eqseg_pkg::VAL_W-1:0] lo;
    logic signed [eqseg_pkg::VAL_W-1:0] hi;
    logic signed [eqseg_pkg::VAL_W-1:0] val;
    logic [eqseg_pkg::CFG_W-1:0]        count;
    logic                               typed;
    placement_t                         want;
  } stim_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;
  logic [0:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [31:0]  out_tdata;
  logic         cfg_we;
  logic [eqseg_pkg::CFG_W-1:0] cfg_wdata;

  // The testbench's own copy of the interval table and of the register.
  // seg_written tracks which entries hold a value, so that no query ever
  // makes the block read an entry that was never loaded.
  logic signed [eqseg_pkg::VAL_W-1:0] seg_lo [eqseg_pkg::MAX_SEGMENTS];
  logic signed [eqseg_pkg::VAL_W-1:0] seg_hi [eqseg_pkg::MAX_SEGMENTS];
  bit                                 seg_written [eqseg_pkg::MAX_SEGMENTS];
  logic [eqseg_pkg::CFG_W-1:0]        seg_count_q;

  // Results of accepted queries, oldest first, waiting for the output side.
  placement_t expected_placements[$];
  stim_row_t  directed_rows[$];
  int         fault_count = 0;
  int         in_gap_pct = 13;
  int         out_stall_pct = 60;

  // Current shape of the well-formed table: entry i covers
  // [base + i*step, base + i*step + span]. The span sets whether the
  // intervals leave gaps, just touch, or overlap.
  longint layout_base;
  longint layout_step;
  longint layout_span;

  equalized_segment_position_lookup dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The cap sits far above the slowest correct run: about 950 words, none
  // slower than a query plus long stalls on both sides.
  initial begin : watchdog
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Segment count actually used by the block. A zero counts as one segment,
  // and anything above the table size is clipped to the table size.
  function automatic int unsigned active_segments();
    int unsigned n;
    n = 32'(seg_count_q);
    if (n < 1) n = 1;
    if (n > eqseg_pkg::MAX_SEGMENTS) n = eqseg_pkg::MAX_SEGMENTS;
    return n;
  endfunction

  // Predicts the answer to a query from the mirrored table. A value below the
  // first entry's upper bound gives zero. A value above the last entry's lower
  // bound gives full scale. Otherwise a binary search runs with asymmetric
  // midpoint updates. All comparisons are signed.
  function automatic placement_t place_value(logic signed [eqseg_pkg::VAL_W-1:0] v);
    placement_t  r;
    int unsigned n;
    int unsigned lo_i;
    int unsigned hi_i;
    int unsigned mid;
    bit          hit;
    r    = '0;
    n    = active_segments();
    lo_i = 0;
    hi_i = n - 1;
    mid  = (n - 1) / 2;
    hit  = 1'b0;
    if (v < seg_hi[0]) begin
      r = '0;
    end else if (v > seg_lo[hi_i]) begin
      r.pos   = eqseg_pkg::FULL_SCALE;
      r.found = eqseg_pkg::FOUND_W'(hi_i);
    end else begin
      // The loop ends with a zero result if no probed interval holds v.
      while (hi_i - lo_i > 1 && !hit) begin
        if (seg_lo[mid] <= v && seg_hi[mid] >= v) begin
          r.pos   = eqseg_pkg::POS_W'((mid << eqseg_pkg::FRAC_W) / n);
          r.found = eqseg_pkg::FOUND_W'(mid);
          hit     = 1'b1;
        end else if (seg_hi[mid] < v) begin
          lo_i = mid;
          mid  = lo_i + (hi_i - lo_i) / 2;
        end else begin
          hi_i = mid;
          mid  = hi_i - (hi_i - lo_i) / 2;
        end
      end
    end
    return r;
  endfunction

  // Presents one word, holding tvalid high until the handshake completes.
  // tvalid is driven low only in the gap loop or by settle_block. A valid
  // held high between back-to-back words therefore never gets two
  // assignments in the same time step.
  task automatic send_word(eqseg_pkg::cmd_t cmd, logic [eqseg_pkg::IDX_W-1:0] idx,
                           logic signed [eqseg_pkg::VAL_W-1:0] lo,
                           logic signed [eqseg_pkg::VAL_W-1:0] hi,
                           logic signed [eqseg_pkg::VAL_W-1:0] val,
                           logic typed, placement_t want);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {val, hi, lo, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // Accepted at this edge: update the mirror or queue the expected result.
    if (cmd == eqseg_pkg::CMD_WRITE) begin
      seg_lo[idx]      = lo;
      seg_hi[idx]      = hi;
      seg_written[idx] = 1'b1;
    end else begin
      expected_placements.push_back(typed ? want : place_value(val));
    end
  endtask

  // Stops sending, waits for every outstanding result, then lets the block
  // finish any trailing table writes, which produce no result word.
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (expected_placements.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // segment_count is written only while the block is idle.
  task automatic program_count(logic [eqseg_pkg::CFG_W-1:0] value);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    seg_count_q = value;
  endtask

  // Picks a new sorted table shape. About one shape in four uses steps of one
  // to four, so that adjacent bounds meet and ties are common.
  function automatic void new_layout();
    layout_base = longint'($urandom_range(0, 32'h6000_0000)) - 64'sh4000_0000;
    layout_step = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(1, 4))
                                              : longint'($urandom_range(16, 1 << 22));
    case ($urandom_range(0, 2))
      0: layout_span = layout_step - 1;
      1: layout_span = layout_step / 2;
      default: layout_span = layout_step + layout_step / 2;
    endcase
  endfunction

  task automatic write_layout_entry(int unsigned i);
    longint lo;
    lo = layout_base + longint'(i) * layout_step;
    send_word(eqseg_pkg::CMD_WRITE, eqseg_pkg::IDX_W'(i), eqseg_pkg::VAL_W'(lo),
              eqseg_pkg::VAL_W'(lo + layout_span), $urandom(), 1'b0, '0);
  endtask

  // Most writes keep the table sorted. The rest hit any entry of the table,
  // also outside the active count, or load arbitrary bounds that may be inverted.
  task automatic random_write(int unsigned n);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      write_layout_entry($urandom_range(0, n - 1));
    end else if (r < 90) begin
      write_layout_entry($urandom_range(0, eqseg_pkg::MAX_SEGMENTS - 1));
    end else begin
      send_word(eqseg_pkg::CMD_WRITE, eqseg_pkg::IDX_W'($urandom()), $urandom(), $urandom(),
                $urandom(), 1'b0, '0);
    end
  endtask

  // Query values come mostly from the bounds of live entries, so that the
  // search often ends on a match. The rest probe both ends of the table and
  // the full signed range. The ignored fields carry random bits.
  task automatic random_query(int unsigned n);
    int unsigned r;
    int unsigned j;
    longint      lo;
    longint      hi;
    longint      v;
    r  = $urandom_range(0, 99);
    j  = $urandom_range(0, n - 1);
    lo = longint'(seg_lo[j]);
    hi = longint'(seg_hi[j]);
    if (r < 60) begin
      case ($urandom_range(0, 4))
        0: v = lo;
        1: v = hi;
        2: v = lo - 1;
        3: v = hi + 1;
        default: v = (lo <= hi) ? lo + $urandom_range(0, 32'(hi - lo)) : lo;
      endcase
    end else if (r < 72) begin
      v = longint'(seg_hi[0]) - $urandom_range(1, 16);
    end else if (r < 84) begin
      v = longint'(seg_lo[n - 1]) + $urandom_range(1, 16);
    end else if (r < 90) begin
      v = $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
    end else begin
      v = longint'($urandom());
    end
    send_word(eqseg_pkg::CMD_QUERY, eqseg_pkg::IDX_W'($urandom()), $urandom(), $urandom(),
              eqseg_pkg::VAL_W'(v), 1'b0, '0);
  endtask

  // Builders for the directed table. The fields that a row's command ignores
  // carry fixed nonzero patterns.
  function automatic stim_row_t entry_row(logic [eqseg_pkg::IDX_W-1:0] idx,
                                          logic signed [eqseg_pkg::VAL_W-1:0] lo,
                                          logic signed [eqseg_pkg::VAL_W-1:0] hi);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_WORD;
    r.cmd  = eqseg_pkg::CMD_WRITE;
    r.idx  = idx;
    r.lo   = lo;
    r.hi   = hi;
    r.val  = 32'sh5A5A_A5A5;
    return r;
  endfunction

  function automatic stim_row_t query_row(logic signed [eqseg_pkg::VAL_W-1:0] v);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_WORD;
    r.cmd  = eqseg_pkg::CMD_QUERY;
    r.idx  = 8'hC3;
    r.lo   = 32'sh7FFF_0000;
    r.hi   = -32'sd1;
    r.val  = v;
    return r;
  endfunction

  function automatic stim_row_t checked_row(logic signed [eqseg_pkg::VAL_W-1:0] v,
                                            logic [eqseg_pkg::POS_W-1:0] pos,
                                            logic [eqseg_pkg::FOUND_W-1:0] found);
    stim_row_t r;
    r            = query_row(v);
    r.typed      = 1'b1;
    r.want.pos   = pos;
    r.want.found = found;
    return r;
  endfunction

  function automatic stim_row_t count_row(logic [eqseg_pkg::CFG_W-1:0] count);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_COUNT;
    r.count = count;
    return r;
  endfunction

  // Output side: takes result words, compares them with the oldest
  // expectation, and drives tready at random from the current stall rate.
  initial begin : result_checker
    placement_t got;
    placement_t want;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.pos   = out_tdata[16:0];
        got.found = out_tdata[24:17];
        if (expected_placements.size() == 0) begin
          $error("result word with no query outstanding: position_fraction %0d, %s %0d",
                 got.pos, "segment_found", got.found);
          fault_count++;
        end else begin
          want = expected_placements.pop_front();
          if (got.pos !== want.pos) begin
            $error("position_fraction: expected %0d, got %0d", want.pos, got.pos);
            fault_count++;
          end
          if (got.found !== want.found) begin
            $error("segment_found: expected %0d, got %0d", want.found, got.found);
            fault_count++;
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  initial begin : stimulus
    stim_row_t                   row;
    int unsigned                 n;
    logic [eqseg_pkg::CFG_W-1:0] count;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    seg_count_q = eqseg_pkg::SEG_COUNT_RESET;

    // Directed part. It first runs at the reset count of 256 segments, with
    // only the first and last entries loaded. Both queries are chosen to
    // resolve at the bound checks, so no other entry is ever read.
    directed_rows.push_back(entry_row(8'd0, -32'sd1000, -32'sd900));
    directed_rows.push_back(entry_row(8'd255, 32'sd900, 32'sd1000));
    directed_rows.push_back(checked_row(32'sh8000_0000, '0, '0));
    directed_rows.push_back(checked_row(32'sh7FFF_FFFF, eqseg_pkg::FULL_SCALE, 8'd255));
    // Four segments, sorted with gaps between them.
    directed_rows.push_back(count_row(9'd4));
    directed_rows.push_back(entry_row(8'd1, -32'sd500, -32'sd400));
    directed_rows.push_back(entry_row(8'd2, 32'sd0, 32'sd100));
    directed_rows.push_back(entry_row(8'd3, 32'sd500, 32'sd600));
    directed_rows.push_back(checked_row(-32'sd901, '0, '0));
    directed_rows.push_back(query_row(-32'sd900));
    directed_rows.push_back(checked_row(32'sd50, 17'd32768, 8'd2));
    directed_rows.push_back(checked_row(32'sd501, eqseg_pkg::FULL_SCALE, 8'd3));
    directed_rows.push_back(query_row(32'sd500));
    directed_rows.push_back(checked_row(-32'sd450, 17'd16384, 8'd1));
    // An inverted interval is used as written, so the search misses it.
    directed_rows.push_back(entry_row(8'd2, 32'sd100, 32'sd0));
    directed_rows.push_back(query_row(32'sd50));
    directed_rows.push_back(entry_row(8'd2, 32'sd0, 32'sd100));
    // With a single segment the search loop never runs. A value equal to
    // both bounds of entry 0 passes the bound checks and still gives zero.
    directed_rows.push_back(entry_row(8'd0, -32'sd900, -32'sd900));
    directed_rows.push_back(count_row(9'd1));
    directed_rows.push_back(checked_row(-32'sd900, '0, '0));
    directed_rows.push_back(checked_row(-32'sd899, eqseg_pkg::FULL_SCALE, 8'd0));
    // A count of zero behaves as one segment.
    directed_rows.push_back(count_row(9'd0));
    directed_rows.push_back(checked_row(-32'sd901, '0, '0));
    directed_rows.push_back(checked_row(-32'sd899, eqseg_pkg::FULL_SCALE, 8'd0));
    directed_rows.push_back(count_row(9'd2));
    directed_rows.push_back(checked_row(-32'sd450, eqseg_pkg::FULL_SCALE, 8'd1));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.kind == ROW_COUNT) begin
        program_count(row.count);
      end else begin
        send_word(row.cmd, row.idx, row.lo, row.hi, row.val, row.typed, row.want);
      end
    end

    // Random part, in three idle profiles: a slow receiver, then a slow
    // sender, then full rate on both sides. Each round reprograms the count,
    // makes sure that every entry a query can reach is loaded, and then mixes
    // queries with writes. Small tables get a fresh sorted shape each round.
    new_layout();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          in_gap_pct    = 13;
          out_stall_pct = 60;
        end
        1: begin
          in_gap_pct    = 60;
          out_stall_pct = 13;
        end
        default: begin
          in_gap_pct    = 0;
          out_stall_pct = 0;
        end
      endcase
      for (int rnd = 0; rnd < ROUNDS; rnd++) begin
        if (rnd == 0) begin
          // Each profile opens at an extreme: the full table, the largest
          // register value (clipped to the table size), and zero.
          case (phase)
            0: count = eqseg_pkg::CFG_W'(eqseg_pkg::MAX_SEGMENTS);
            1: count = '1;
            default: count = '0;
          endcase
        end else begin
          case ($urandom_range(0, 9))
            0: count = '0;
            1: count = 9'd1;
            2: count = 9'd2;
            3: count = eqseg_pkg::CFG_W'(eqseg_pkg::MAX_SEGMENTS);
            4: count = eqseg_pkg::CFG_W'($urandom_range(eqseg_pkg::MAX_SEGMENTS + 1, 511));
            5: count = eqseg_pkg::CFG_W'($urandom_range(129, 255));
            default: count = eqseg_pkg::CFG_W'($urandom_range(3, 32));
          endcase
        end
        program_count(count);
        n = active_segments();
        if (n <= 32) begin
          new_layout();
          for (int unsigned i = 0; i < n; i++) write_layout_entry(i);
        end else begin
          for (int unsigned i = 0; i < n; i++) begin
            if (!seg_written[i]) write_layout_entry(i);
          end
        end
        repeat (ROUND_WORDS) begin
          if ($urandom_range(0, 99) < 30) random_write(n);
          else random_query(n);
        end
      end
    end

    settle_block();
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
src/eqseg_pkg.sv
src/eqseg_front.sv
src/eqseg_queue.sv
src/eqseg_back.sv
src/equalized_segment_position_lookup.sv
sim/tb.sv
